FILE: design/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
`timescale 1ns / 1ps

package uer_pkg;

    // Configuration port geometry and register indexes.
    localparam int CFG_W     = 20;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MM  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 3'd5;

    // Register values after reset.
    localparam logic [19:0] TIMEOUT_RST = 20'd200000;
    localparam logic [15:0] MIN_MM_RST  = 16'd20;
    localparam logic [15:0] MAX_MM_RST  = 16'd4000;
    localparam logic [15:0] NOISE_RST   = 16'd100;
    localparam logic [19:0] GAP_RST     = 20'd50000;
    localparam logic [7:0]  TRIGGER_RST = 8'd10;

    // Fixed parts of one attempt and the sound speed scaling.
    localparam int PRE_TICKS  = 5;
    localparam int POST_TICKS = 10;
    localparam logic [11:0] SOUND_MUL = 12'd343;
    localparam logic [11:0] SOUND_DIV = 12'd2000;

    typedef struct packed {
        logic start_req;
        logic echo;
    } req_t;

    typedef struct packed {
        logic        trigger;
        logic        busy_res;
        logic        done_res;
        logic [15:0] distance_mm;
        logic        status;
        logic [2:0]  readings_used;
    } res_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE,
        PH_TRIG,
        PH_POST,
        PH_RISE,
        PH_HIGH,
        PH_GAP
    } phase_t;

    typedef enum logic [1:0] {
        CS_TAKE,
        CS_STEP,
        CS_SORT,
        CS_EMIT
    } ctl_state_t;

    typedef enum logic [1:0] {
        TMR_HOLD,
        TMR_CLEAR,
        TMR_INC,
        TMR_ONE
    } tmr_op_t;

    typedef enum logic [1:0] {
        REC_NONE,
        REC_MAX,
        REC_DIST
    } rec_op_t;

    typedef struct packed {
        logic    capture;
        tmr_op_t tmr_op;
        logic    seq_clr;
        logic    att_inc;
        rec_op_t rec_op;
        logic    sort_init;
        logic    sort_pass;
        logic    out_load;
        logic    out_trig;
        logic    out_busy;
        logic    out_done;
    } dp_cmd_t;

    typedef struct packed {
        logic start;
        logic echo;
        logic pre_done;
        logic trig_done;
        logic post_done;
        logic rise_timeout;
        logic at_limit;
        logic short_pulse;
        logic gap_done;
        logic gap_zero;
        logic last_attempt;
        logic sort_last;
    } dp_status_t;

endpackage

FILE: design/uer_dp.sv
// Datapath of the echo ranger: configuration, timers, reading store, sorter and result register.
`timescale 1ns / 1ps

module uer_dp
    import uer_pkg::*;
#(
    parameter int ATTEMPTS   = 5,
    parameter int TIMER_BITS = 20
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  req_t                 req,
    input  dp_cmd_t              cmd,
    output dp_status_t           sts,
    output res_t                 res
);

    localparam int CNT_W  = $clog2(ATTEMPTS + 1);
    localparam int IDX_W  = (ATTEMPTS > 1) ? $clog2(ATTEMPTS) : 1;
    localparam int SECOND = (ATTEMPTS > 1) ? 1 : 0;
    localparam logic [31:0] TMASK = 32'((33'd1 << TIMER_BITS) - 33'd1);

    logic [19:0] timeout_reg;
    logic [15:0] min_reg;
    logic [15:0] max_reg;
    logic [15:0] noise_reg;
    logic [19:0] gap_reg;
    logic [7:0]  trig_w_reg;

    logic start_reg;
    logic echo_reg;

    logic [TIMER_BITS-1:0] timer_reg;
    logic [TIMER_BITS-1:0] q_reg;
    logic [10:0]           r_reg;
    logic [CNT_W-1:0]      att_reg;
    logic [CNT_W-1:0]      vcnt_reg;
    logic [CNT_W-1:0]      pass_reg;
    logic                  parity_reg;
    logic [15:0]           store_reg [ATTEMPTS];
    logic [15:0]           sort_next [ATTEMPTS];
    res_t                  res_reg;

    logic [31:0]           timeout_w;
    logic [31:0]           gap_w;
    logic [31:0]           lim32;
    logic [31:0]           gap32;
    logic [TIMER_BITS-1:0] limit;
    logic [TIMER_BITS-1:0] gap_lim;
    logic [7:0]            trig_w;
    logic [TIMER_BITS:0]   tmr_inc;
    logic [11:0]           r_sum;
    logic [11:0]           r_wrap;
    logic [15:0]           mm_clamp;
    logic [15:0]           rec_val;
    logic [CNT_W-1:0]      half;
    logic [16:0]           sum2;
    logic [15:0]           dist_sel;
    logic                  stat_sel;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg <= TIMEOUT_RST;
            min_reg     <= MIN_MM_RST;
            max_reg     <= MAX_MM_RST;
            noise_reg   <= NOISE_RST;
            gap_reg     <= GAP_RST;
            trig_w_reg  <= TRIGGER_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                CFG_TIMEOUT: timeout_reg <= cfg_wdata;
                CFG_MIN_MM:  min_reg     <= cfg_wdata[15:0];
                CFG_MAX_MM:  max_reg     <= cfg_wdata[15:0];
                CFG_NOISE:   noise_reg   <= cfg_wdata[15:0];
                CFG_GAP:     gap_reg     <= cfg_wdata;
                CFG_TRIGGER: trig_w_reg  <= cfg_wdata[7:0];
                default:     ;
            endcase
        end
    end

    // Limits are saturated to the timer width; zero timeout and zero width act as one.
    always_comb
    begin
        timeout_w = 32'(timeout_reg);
        gap_w     = 32'(gap_reg);
        if (timeout_reg == 20'd0)
            lim32 = 32'd1;
        else if (timeout_w > TMASK)
            lim32 = TMASK;
        else
            lim32 = timeout_w;
        gap32   = (gap_w > TMASK) ? TMASK : gap_w;
        limit   = lim32[TIMER_BITS-1:0];
        gap_lim = gap32[TIMER_BITS-1:0];
        trig_w  = (trig_w_reg == 8'd0) ? 8'd1 : trig_w_reg;
        tmr_inc = {1'b0, timer_reg} + (TIMER_BITS+1)'(1);
    end

    // The quotient and remainder track timer*343 = q*2000 + r while the echo is high.
    always_comb
    begin
        r_sum  = {1'b0, r_reg} + SOUND_MUL;
        r_wrap = r_sum - SOUND_DIV;
        if (32'(q_reg) > 32'(max_reg))
            mm_clamp = max_reg;
        else if (32'(q_reg) < 32'(min_reg))
            mm_clamp = min_reg;
        else
            mm_clamp = q_reg[15:0];
        rec_val = (cmd.rec_op == REC_MAX) ? max_reg : mm_clamp;
    end

    always_comb
    begin
        sts.start        = start_reg;
        sts.echo         = echo_reg;
        sts.pre_done     = tmr_inc >= (TIMER_BITS+1)'(PRE_TICKS);
        sts.trig_done    = tmr_inc >= (TIMER_BITS+1)'(trig_w);
        sts.post_done    = tmr_inc >= (TIMER_BITS+1)'(POST_TICKS);
        sts.rise_timeout = tmr_inc >= {1'b0, limit};
        sts.at_limit     = timer_reg >= limit;
        sts.short_pulse  = 32'(timer_reg) < 32'(noise_reg);
        sts.gap_done     = tmr_inc >= {1'b0, gap_lim};
        sts.gap_zero     = (gap_reg == 20'd0);
        sts.last_attempt = ({1'b0, att_reg} + (CNT_W+1)'(1)) >= (CNT_W+1)'(ATTEMPTS);
        sts.sort_last    = (pass_reg == CNT_W'(ATTEMPTS - 1));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            start_reg <= req.start_req;
            echo_reg  <= req.echo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_reg <= '0;
        end
        else
        begin
            case (cmd.tmr_op)
                TMR_CLEAR: timer_reg <= '0;
                TMR_INC:   timer_reg <= tmr_inc[TIMER_BITS-1:0];
                TMR_ONE:   timer_reg <= TIMER_BITS'(1);
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.tmr_op)
            TMR_INC:
            begin
                if (r_sum >= SOUND_DIV)
                begin
                    q_reg <= q_reg + TIMER_BITS'(1);
                    r_reg <= r_wrap[10:0];
                end
                else
                begin
                    r_reg <= r_sum[10:0];
                end
            end
            TMR_ONE:
            begin
                q_reg <= '0;
                r_reg <= SOUND_MUL[10:0];
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            att_reg    <= '0;
            vcnt_reg   <= '0;
            pass_reg   <= '0;
            parity_reg <= 1'b0;
        end
        else
        begin
            if (cmd.seq_clr)
            begin
                att_reg  <= '0;
                vcnt_reg <= '0;
            end
            else
            begin
                if (cmd.att_inc)
                    att_reg <= att_reg + CNT_W'(1);
                if (cmd.rec_op != REC_NONE)
                    vcnt_reg <= vcnt_reg + CNT_W'(1);
            end
            if (cmd.sort_init)
            begin
                pass_reg   <= '0;
                parity_reg <= 1'b0;
            end
            else if (cmd.sort_pass)
            begin
                pass_reg   <= pass_reg + CNT_W'(1);
                parity_reg <= ~parity_reg;
            end
        end
    end

    // One odd-even transposition pass over the recorded lanes.
    always_comb
    begin
        for (int i = 0; i < ATTEMPTS; i++)
            sort_next[i] = store_reg[i];
        for (int i = 0; i < ATTEMPTS - 1; i++)
        begin
            if (((i % 2) == int'(parity_reg)) && ((i + 1) < int'(vcnt_reg))
                && (store_reg[i] > store_reg[i+1]))
            begin
                sort_next[i]   = store_reg[i+1];
                sort_next[i+1] = store_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sort_pass)
        begin
            for (int i = 0; i < ATTEMPTS; i++)
                store_reg[i] <= sort_next[i];
        end
        else if ((cmd.rec_op != REC_NONE) && (vcnt_reg < CNT_W'(ATTEMPTS)))
        begin
            store_reg[vcnt_reg[IDX_W-1:0]] <= rec_val;
        end
    end

    always_comb
    begin
        half     = vcnt_reg >> 1;
        sum2     = {1'b0, store_reg[0]} + {1'b0, store_reg[SECOND]};
        stat_sel = 1'b0;
        if (vcnt_reg == '0)
        begin
            dist_sel = 16'd0;
            stat_sel = 1'b1;
        end
        else if (vcnt_reg == CNT_W'(1))
            dist_sel = store_reg[0];
        else if (vcnt_reg == CNT_W'(2))
            dist_sel = sum2[16:1];
        else
            dist_sel = store_reg[half[IDX_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            res_reg.trigger  <= cmd.out_trig;
            res_reg.busy_res <= cmd.out_busy;
            res_reg.done_res <= cmd.out_done;
            if (cmd.out_done)
            begin
                res_reg.distance_mm   <= dist_sel;
                res_reg.status        <= stat_sel;
                res_reg.readings_used <= 3'(vcnt_reg);
            end
            else
            begin
                res_reg.distance_mm   <= 16'd0;
                res_reg.status        <= 1'b0;
                res_reg.readings_used <= 3'd0;
            end
        end
    end

    assign res = res_reg;

    // Every recorded reading belongs to a finished attempt.
    assert property (@(posedge clk) disable iff (!rst_n) vcnt_reg <= att_reg)
        else $error("more readings recorded than attempts made");

    assert property (@(posedge clk) disable iff (!rst_n) att_reg <= CNT_W'(ATTEMPTS))
        else $error("attempt index ran past the attempt count");

endmodule

FILE: design/uer_ctrl.sv
// Controller of the echo ranger: item sequencing and the measurement phase machine.
`timescale 1ns / 1ps

module uer_ctrl
    import uer_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic       res_ready,
    output logic       res_valid,
    input  dp_status_t sts,
    output dp_cmd_t    cmd
);

    ctl_state_t state_reg;
    ctl_state_t state_next;
    phase_t     phase_reg;
    phase_t     phase_next;
    logic       trig_reg;
    logic       trig_next;
    logic       busy_reg;
    logic       busy_next;
    logic       done_reg;
    logic       done_next;
    logic       res_valid_reg;
    logic       res_valid_next;

    phase_t  dec_phase;
    tmr_op_t dec_tmr;
    rec_op_t dec_rec;
    logic    dec_seq_clr;
    logic    dec_end;
    logic    dec_recorded;
    logic    dec_fin;
    logic    dec_trig;
    logic    dec_busy;
    logic    out_free;

    assign out_free = !res_valid_reg || res_ready;

    // What one tick does to the measurement, decided from the current phase.
    always_comb
    begin
        dec_phase    = phase_reg;
        dec_tmr      = TMR_HOLD;
        dec_rec      = REC_NONE;
        dec_seq_clr  = 1'b0;
        dec_end      = 1'b0;
        dec_recorded = 1'b0;
        dec_fin      = 1'b0;
        dec_trig     = 1'b0;
        dec_busy     = 1'b1;
        case (phase_reg)
            PH_IDLE:
            begin
                if (sts.start)
                begin
                    dec_seq_clr = 1'b1;
                    dec_tmr     = TMR_ONE;
                    dec_phase   = PH_PRE;
                end
                else
                begin
                    dec_busy = 1'b0;
                end
            end
            PH_PRE:
            begin
                if (sts.pre_done)
                begin
                    dec_phase = PH_TRIG;
                    dec_tmr   = TMR_CLEAR;
                end
                else
                    dec_tmr = TMR_INC;
            end
            PH_TRIG:
            begin
                dec_trig = 1'b1;
                if (sts.trig_done)
                begin
                    dec_phase = PH_POST;
                    dec_tmr   = TMR_CLEAR;
                end
                else
                    dec_tmr = TMR_INC;
            end
            PH_POST:
            begin
                if (sts.post_done)
                begin
                    dec_phase = PH_RISE;
                    dec_tmr   = TMR_CLEAR;
                end
                else
                    dec_tmr = TMR_INC;
            end
            PH_RISE:
            begin
                if (sts.echo)
                begin
                    dec_phase = PH_HIGH;
                    dec_tmr   = TMR_ONE;
                end
                else if (sts.rise_timeout)
                    dec_end = 1'b1;
                else
                    dec_tmr = TMR_INC;
            end
            PH_HIGH:
            begin
                if (sts.echo)
                begin
                    if (sts.at_limit)
                    begin
                        dec_rec      = REC_MAX;
                        dec_end      = 1'b1;
                        dec_recorded = 1'b1;
                    end
                    else
                        dec_tmr = TMR_INC;
                end
                else if (sts.short_pulse)
                    dec_end = 1'b1;
                else
                begin
                    dec_rec      = REC_DIST;
                    dec_end      = 1'b1;
                    dec_recorded = 1'b1;
                end
            end
            PH_GAP:
            begin
                if (sts.gap_done)
                begin
                    dec_phase = PH_PRE;
                    dec_tmr   = TMR_CLEAR;
                end
                else
                    dec_tmr = TMR_INC;
            end
            default:
            begin
                dec_phase = PH_IDLE;
            end
        endcase
        if (dec_end)
        begin
            dec_tmr = TMR_CLEAR;
            if (sts.last_attempt)
            begin
                dec_phase = PH_IDLE;
                dec_fin   = 1'b1;
                dec_busy  = 1'b0;
            end
            else if (dec_recorded && !sts.gap_zero)
                dec_phase = PH_GAP;
            else
                dec_phase = PH_PRE;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        trig_next      = trig_reg;
        busy_next      = busy_reg;
        done_next      = done_reg;
        res_valid_next = res_valid_reg;
        if (res_ready)
            res_valid_next = 1'b0;
        case (state_reg)
            CS_TAKE:
            begin
                if (req_valid)
                    state_next = CS_STEP;
            end
            CS_STEP:
            begin
                phase_next = dec_phase;
                trig_next  = dec_trig;
                busy_next  = dec_busy;
                done_next  = dec_fin;
                state_next = dec_fin ? CS_SORT : CS_EMIT;
            end
            CS_SORT:
            begin
                if (sts.sort_last)
                    state_next = CS_EMIT;
            end
            CS_EMIT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    state_next     = CS_TAKE;
                end
            end
            default:
            begin
                state_next = CS_TAKE;
            end
        endcase
    end

    always_comb
    begin
        cmd           = '0;
        cmd.tmr_op    = TMR_HOLD;
        cmd.rec_op    = REC_NONE;
        cmd.out_trig  = trig_reg;
        cmd.out_busy  = busy_reg;
        cmd.out_done  = done_reg;
        req_ready     = 1'b0;
        case (state_reg)
            CS_TAKE:
            begin
                req_ready   = 1'b1;
                cmd.capture = req_valid;
            end
            CS_STEP:
            begin
                cmd.tmr_op    = dec_tmr;
                cmd.rec_op    = dec_rec;
                cmd.seq_clr   = dec_seq_clr;
                cmd.att_inc   = dec_end;
                cmd.sort_init = dec_fin;
            end
            CS_SORT:
            begin
                cmd.sort_pass = 1'b1;
            end
            CS_EMIT:
            begin
                cmd.out_load = out_free;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CS_TAKE;
            phase_reg     <= PH_IDLE;
            trig_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            trig_reg      <= trig_next;
            busy_reg      <= busy_next;
            done_reg      <= done_next;
            res_valid_reg <= res_valid_next;
        end
    end

    assign res_valid = res_valid_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == CS_STEP))
        else $error("accepted item was not stepped");

    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(phase_reg) |-> $past(state_reg == CS_STEP))
        else $error("phase changed outside a tick step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == CS_SORT) |=> (state_reg == CS_SORT || state_reg == CS_EMIT))
        else $error("sort left for an unexpected state");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.out_load && cmd.out_done) |-> (!cmd.out_busy && phase_reg == PH_IDLE))
        else $error("finishing item while the sequence is still running");

endmodule

FILE: design/ultrasonic_echo_ranger_top.sv
// Top level of the ultrasonic echo ranger with median filtering over several attempts.
`timescale 1ns / 1ps

// Each input item is one microsecond tick and yields exactly one result item. An item is
// taken, stepped through the phase machine in the following cycle and written to the
// output register in the emit state, which waits while an older result is unread; the tick
// ending the last attempt first runs ATTEMPTS odd-even sort passes over the stored readings.
// The output register lets the next item in while a result still waits. Configuration is
// written through cfg_we, cfg_idx and cfg_wdata, one register per cycle; the user must
// do so only while no item is in flight, since the block itself does not enforce this.
module ultrasonic_echo_ranger_top
    import uer_pkg::*;
#(
    parameter int ATTEMPTS   = 5,
    parameter int TIMER_BITS = 20
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_idx,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  req_t                 req,
    output logic                 res_valid,
    input  logic                 res_ready,
    output res_t                 res
);

    dp_cmd_t    cmd;
    dp_status_t sts;

    uer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .sts       (sts),
        .cmd       (cmd)
    );

    uer_dp #(
        .ATTEMPTS   (ATTEMPTS),
        .TIMER_BITS (TIMER_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .res       (res)
    );

endmodule
